FILE: rtl/rstf_pkg.sv
// Shared types, constants and helpers for the rectangular element stiffness core.
// No dependencies; every other file but rstf_checker imports this package.
`timescale 1ns / 1ps

package rstf_pkg;

  localparam int MAX_STEPS = 64;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int GRID_W    = 7;
  localparam int SUM_W     = 3 * STEP_W + 3;
  localparam int DEN_W     = 3 * STEP_W + 2;
  localparam int WORD_W    = 64;
  localparam int FRAC_W    = 32;
  localparam int NUM_W     = WORD_W + FRAC_W;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int HALF_W    = WORD_W / 2;

  localparam logic signed [WORD_W-1:0] QUARTER   = 64'sh0000_0000_4000_0000;
  localparam logic signed [WORD_W-1:0] SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] SAT_MIN   = 64'sh8000_0000_0000_0000;

  // configuration register indexes
  localparam logic [2:0] REG_GRID_STEPS = 3'd0;
  localparam logic [2:0] REG_ELASTIC_XX = 3'd1;
  localparam logic [2:0] REG_ELASTIC_XY = 3'd2;
  localparam logic [2:0] REG_ELASTIC_XS = 3'd3;
  localparam logic [2:0] REG_ELASTIC_YY = 3'd4;
  localparam logic [2:0] REG_ELASTIC_YS = 3'd5;
  localparam logic [2:0] REG_ELASTIC_SS = 3'd6;

  // divider jobs
  localparam logic [1:0] DIV_RH = 2'd0;
  localparam logic [1:0] DIV_RW = 2'd1;
  localparam logic [1:0] DIV_GA = 2'd2;
  localparam logic [1:0] DIV_GB = 2'd3;

  // per-element products of elasticity and aspect ratio
  localparam logic [2:0] PRE_XX_RH = 3'd0;
  localparam logic [2:0] PRE_SS_RW = 3'd1;
  localparam logic [2:0] PRE_XS_RH = 3'd2;
  localparam logic [2:0] PRE_YS_RW = 3'd3;
  localparam logic [2:0] PRE_YY_RW = 3'd4;
  localparam logic [2:0] PRE_SS_RH = 3'd5;
  localparam int         PRE_NUM   = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOX,
    ST_CHK,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PRE_GO,
    ST_PRE_WAIT,
    ST_TERM_GO,
    ST_TERM_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_UU,
    KIND_UV,
    KIND_VV
  } kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [WORD_W-1:0] sat_add(
    input logic signed [WORD_W-1:0] a,
    input logic signed [WORD_W-1:0] b
  );
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? SAT_MIN : SAT_MAX;
    end
    return s[WORD_W-1:0];
  endfunction

endpackage

FILE: rtl/rstf_mul.sv
// Sequential Q32.32 multiplier: four 32x32 partial products, rounding and saturation.
// Depends on rstf_pkg.
`timescale 1ns / 1ps

module rstf_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [rstf_pkg::WORD_W-1:0] a,
  input  logic signed [rstf_pkg::WORD_W-1:0] b,
  output logic signed [rstf_pkg::WORD_W-1:0] result,
  output rstf_pkg::unit_stat_t               stat
);
  import rstf_pkg::*;

  logic [WORD_W-1:0] ma, mb;
  logic              neg;
  logic [PROD_W-1:0] acc;
  logic [2:0]        step;
  logic              busy, done;

  logic [HALF_W-1:0] ha, hb;
  logic [WORD_W-1:0] pp;
  logic [PROD_W-1:0] pp_sh;
  logic [PROD_W-1:0] rnd;
  logic [WORD_W-1:0] rmag;
  logic signed [WORD_W-1:0] fin;

  assign ha = step[1] ? ma[WORD_W-1:HALF_W] : ma[HALF_W-1:0];
  assign hb = step[0] ? mb[WORD_W-1:HALF_W] : mb[HALF_W-1:0];
  assign pp = ha * hb;

  always_comb begin
    case ({1'b0, step[1]} + {1'b0, step[0]})
      2'd0:    pp_sh = PROD_W'(pp);
      2'd1:    pp_sh = PROD_W'(pp) << HALF_W;
      2'd2:    pp_sh = PROD_W'(pp) << WORD_W;
      default: pp_sh = '0;
    endcase
  end

  // round to nearest, ties away from zero, then saturate on the signed range
  always_comb begin
    rnd  = acc + (PROD_W'(1) << (FRAC_W - 1));
    rmag = rnd[NUM_W-1:FRAC_W];
    if (rnd[PROD_W-1:NUM_W] != '0) begin
      fin = neg ? SAT_MIN : SAT_MAX;
    end else if (!neg) begin
      fin = rmag[WORD_W-1] ? SAT_MAX : $signed(rmag);
    end else if (rmag[WORD_W-1]) begin
      fin = SAT_MIN;
    end else begin
      fin = -$signed(rmag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
      mb  <= b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
      neg <= a[WORD_W-1] ^ b[WORD_W-1];
      acc <= '0;
    end else if (busy) begin
      if (step == 3'd4) begin
        result <= fin;
      end else begin
        acc <= acc + pp_sh;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/rstf_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to the signed range.
// Depends on rstf_pkg.
`timescale 1ns / 1ps

module rstf_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [rstf_pkg::NUM_W-1:0]         dividend,
  input  logic [rstf_pkg::WORD_W-1:0]        divisor,
  output logic signed [rstf_pkg::WORD_W-1:0] quotient,
  output rstf_pkg::unit_stat_t               stat
);
  import rstf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  q;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] den;
  logic [CNT_W-1:0]  cnt;
  logic              busy, done;

  logic [WORD_W:0]   rem2;
  logic              ge;
  logic [WORD_W:0]   diff;

  assign rem2 = {rem, num[NUM_W-1]};
  assign ge   = rem2 >= {1'b0, den};
  assign diff = rem2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      num <= num << 1;
      rem <= ge ? diff[WORD_W-1:0] : rem2[WORD_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

  assign quotient = (q[NUM_W-1:WORD_W-1] != '0) ? SAT_MAX : $signed(q[WORD_W-1:0]);
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/rect_element_stiffness_core.sv
// Bilinear rectangular element stiffness: 64 entries per element, row-major.
// One element at a time; a flat element goes straight to its output. All products run
// through one shared multiplier and all quotients through one shared divider.
// Reset (synchronous, rst high) returns to idle with steps 2 and elasticity zero.
`timescale 1ns / 1ps

module rect_element_stiffness_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [63:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [63:0]                 corner1_x,
  input  logic signed [63:0]                 corner1_y,
  input  logic signed [63:0]                 corner2_x,
  input  logic signed [63:0]                 corner2_y,
  input  logic signed [63:0]                 corner3_x,
  input  logic signed [63:0]                 corner3_y,
  input  logic signed [63:0]                 corner4_x,
  input  logic signed [63:0]                 corner4_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         row_index,
  output logic [2:0]                         column_index,
  output logic signed [63:0]                 stiffness_value,
  output logic                               last_entry,
  output logic                               zero_area
);
  import rstf_pkg::*;

  state_t state, state_next;

  logic [GRID_W-1:0]        grid_steps;
  logic signed [WORD_W-1:0] exx, exy, exs, eyy, eys, ess;

  logic signed [WORD_W-1:0] cx [4];
  logic signed [WORD_W-1:0] cy [4];
  logic signed [WORD_W-1:0] xmin, xmax, ymin, ymax;
  logic [1:0]               bi;
  logic [WORD_W-1:0]        w, h;
  logic                     flat;

  logic [STEP_W-1:0]        ncl;
  logic [2*STEP_W-1:0]      nsq;
  logic [DEN_W-1:0]         den;
  logic [STEP_W-1:0]        k;
  logic signed [SUM_W-1:0]  stt, stu;

  logic [1:0]               div_idx;
  logic [2:0]               pre_idx;
  logic signed [WORD_W-1:0] rh, rw, ga, gb;
  logic signed [WORD_W-1:0] pre_v [PRE_NUM];

  logic [5:0]               e;
  logic [1:0]               ti;
  logic signed [WORD_W-1:0] stiff;

  logic                     in_xfer, out_xfer;
  logic                     mul_start, div_start;
  logic signed [WORD_W-1:0] mul_a, mul_b, mul_res, div_q;
  logic [NUM_W-1:0]         div_num;
  logic [WORD_W-1:0]        div_den;
  unit_stat_t               mul_stat, div_stat;

  // clamp the step count into range
  always_comb begin
    if (grid_steps == '0) begin
      ncl = STEP_W'(1);
    end else if (grid_steps > GRID_W'(MAX_STEPS)) begin
      ncl = STEP_W'(MAX_STEPS);
    end else begin
      ncl = STEP_W'(grid_steps);
    end
  end

  // midpoint sample sums: t = 2k+1, u = t - 2n
  logic [STEP_W:0]            t_c;
  logic signed [STEP_W+1:0]   u_c;
  logic [2*STEP_W+1:0]        prod_tt;
  logic signed [2*STEP_W+3:0] prod_tu;

  assign t_c     = {k, 1'b1};
  assign u_c     = $signed({1'b0, t_c}) - $signed({1'b0, ncl, 1'b0});
  assign prod_tt = t_c * t_c;
  assign prod_tu = $signed({1'b0, t_c}) * u_c;

  logic signed [WORD_W-1:0] w_c, h_c;
  assign w_c = xmax - xmin;
  assign h_c = ymax - ymin;

  // divider operands
  logic [SUM_W-1:0] mag_stt, mag_stu;
  assign mag_stt = stt[SUM_W-1] ? SUM_W'(-stt) : SUM_W'(stt);
  assign mag_stu = stu[SUM_W-1] ? SUM_W'(-stu) : SUM_W'(stu);

  always_comb begin
    div_den = WORD_W'(den);
    case (div_idx)
      DIV_RH: begin
        div_num = {h, {FRAC_W{1'b0}}};
        div_den = w;
      end
      DIV_RW: begin
        div_num = {w, {FRAC_W{1'b0}}};
        div_den = h;
      end
      DIV_GA:  div_num = (NUM_W'(mag_stt) << FRAC_W) + NUM_W'(den >> 1);
      default: div_num = (NUM_W'(mag_stu) << FRAC_W) + NUM_W'(den >> 1);
    endcase
  end

  // entry decode
  kind_t      kind;
  logic [1:0] m, p;
  logic [1:0] ti_last;

  always_comb begin
    if (!e[5] && !e[2]) begin
      kind = KIND_UU;
    end else if (e[5] && e[2]) begin
      kind = KIND_VV;
    end else begin
      kind = KIND_UV;
    end
    if (e[5] && !e[2]) begin
      m = e[1:0];
      p = e[4:3];
    end else begin
      m = e[4:3];
      p = e[1:0];
    end
    ti_last = (kind == KIND_UV) ? 2'd3 : 2'd2;
  end

  logic signed [WORD_W-1:0] gsel_x, gsel_y, gx, gy, cyx, cxy, csum;

  always_comb begin
    gsel_x = ((m[0] ^ m[1]) == (p[0] ^ p[1])) ? ga : gb;
    gsel_y = (m[1] == p[1]) ? ga : gb;
    gx     = (m[0] ^ p[0]) ? -gsel_x : gsel_x;
    gy     = (m[0] ^ p[0]) ? -gsel_y : gsel_y;
    // sign_x is positive for nodes 2,3; sign_y for nodes 1,2
    cyx    = ((m[0] ^ m[1]) == p[1]) ? QUARTER : -QUARTER;
    cxy    = (m[1] == (p[0] ^ p[1])) ? QUARTER : -QUARTER;
    csum   = cyx + cxy;
  end

  // multiplier operands
  always_comb begin
    mul_a = exx;
    mul_b = rh;
    if (state == ST_PRE_GO) begin
      case (pre_idx)
        PRE_XX_RH: begin mul_a = exx; mul_b = rh; end
        PRE_SS_RW: begin mul_a = ess; mul_b = rw; end
        PRE_XS_RH: begin mul_a = exs; mul_b = rh; end
        PRE_YS_RW: begin mul_a = eys; mul_b = rw; end
        PRE_YY_RW: begin mul_a = eyy; mul_b = rw; end
        default:   begin mul_a = ess; mul_b = rh; end
      endcase
    end else begin
      case (kind)
        KIND_UU: begin
          case (ti)
            2'd0:    begin mul_a = pre_v[PRE_XX_RH]; mul_b = gy; end
            2'd1:    begin mul_a = exs; mul_b = csum; end
            default: begin mul_a = pre_v[PRE_SS_RW]; mul_b = gx; end
          endcase
        end
        KIND_UV: begin
          case (ti)
            2'd0:    begin mul_a = exy; mul_b = cyx; end
            2'd1:    begin mul_a = pre_v[PRE_XS_RH]; mul_b = gy; end
            2'd2:    begin mul_a = pre_v[PRE_YS_RW]; mul_b = gx; end
            default: begin mul_a = ess; mul_b = cxy; end
          endcase
        end
        default: begin
          case (ti)
            2'd0:    begin mul_a = pre_v[PRE_YY_RW]; mul_b = gx; end
            2'd1:    begin mul_a = eys; mul_b = csum; end
            default: begin mul_a = pre_v[PRE_SS_RH]; mul_b = gy; end
          endcase
        end
      endcase
    end
  end

  rstf_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .result (mul_res),
    .stat   (mul_stat)
  );

  rstf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_xfer) state_next = ST_BOX;
      ST_BOX:       if (bi == 2'd3) state_next = ST_CHK;
      ST_CHK:       state_next = (w_c == '0 || h_c == '0) ? ST_OUT : ST_SUM;
      ST_SUM:       if (k == ncl - STEP_W'(1)) state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = (div_idx == DIV_GB) ? ST_PRE_GO : ST_DIV_GO;
        end
      end
      ST_PRE_GO:    state_next = ST_PRE_WAIT;
      ST_PRE_WAIT: begin
        if (mul_stat.done) begin
          state_next = (pre_idx == 3'(PRE_NUM - 1)) ? ST_TERM_GO : ST_PRE_GO;
        end
      end
      ST_TERM_GO:   state_next = ST_TERM_WAIT;
      ST_TERM_WAIT: begin
        if (mul_stat.done && ti == ti_last) state_next = ST_OUT;
        else if (mul_stat.done) state_next = ST_TERM_GO;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (e == 6'd63) state_next = ST_IDLE;
          else if (!flat) state_next = ST_TERM_GO;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state == ST_IDLE) && !mul_stat.busy && !div_stat.busy;
    out_valid = (state == ST_OUT);
    mul_start = (state == ST_PRE_GO) || (state == ST_TERM_GO);
    div_start = (state == ST_DIV_GO);
  end

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      grid_steps <= GRID_W'(2);
      exx        <= '0;
      exy        <= '0;
      exs        <= '0;
      eyy        <= '0;
      eys        <= '0;
      ess        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_STEPS: grid_steps <= cfg_data[GRID_W-1:0];
          REG_ELASTIC_XX: exx <= cfg_data;
          REG_ELASTIC_XY: exy <= cfg_data;
          REG_ELASTIC_XS: exs <= cfg_data;
          REG_ELASTIC_YY: eyy <= cfg_data;
          REG_ELASTIC_YS: eys <= cfg_data;
          REG_ELASTIC_SS: ess <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          cx[0] <= corner1_x; cy[0] <= corner1_y;
          cx[1] <= corner2_x; cy[1] <= corner2_y;
          cx[2] <= corner3_x; cy[2] <= corner3_y;
          cx[3] <= corner4_x; cy[3] <= corner4_y;
          xmin  <= corner1_x; xmax <= corner1_x;
          ymin  <= corner1_y; ymax <= corner1_y;
          bi    <= 2'd1;
        end
      end
      ST_BOX: begin
        if (cx[bi] < xmin) xmin <= cx[bi];
        if (cx[bi] > xmax) xmax <= cx[bi];
        if (cy[bi] < ymin) ymin <= cy[bi];
        if (cy[bi] > ymax) ymax <= cy[bi];
        bi  <= bi + 2'd1;
        nsq <= ncl * ncl;
        den <= (DEN_W'(nsq) * DEN_W'(ncl)) << 2;
      end
      ST_CHK: begin
        w     <= w_c;
        h     <= h_c;
        flat  <= (w_c == '0) || (h_c == '0);
        stt   <= '0;
        stu   <= '0;
        k     <= '0;
        div_idx <= DIV_RH;
        pre_idx <= PRE_XX_RH;
        e     <= '0;
        ti    <= '0;
        stiff <= '0;
      end
      ST_SUM: begin
        stt <= stt + SUM_W'(prod_tt);
        stu <= stu + SUM_W'(prod_tu);
        k   <= k + STEP_W'(1);
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          case (div_idx)
            DIV_RH:  rh <= div_q;
            DIV_RW:  rw <= div_q;
            DIV_GA:  ga <= stt[SUM_W-1] ? -div_q : div_q;
            default: gb <= stu[SUM_W-1] ? -div_q : div_q;
          endcase
          div_idx <= div_idx + 2'd1;
        end
      end
      ST_PRE_WAIT: begin
        if (mul_stat.done) begin
          pre_v[pre_idx] <= mul_res;
          pre_idx        <= pre_idx + 3'd1;
        end
      end
      ST_TERM_WAIT: begin
        if (mul_stat.done) begin
          stiff <= (ti == 2'd0) ? mul_res : sat_add(stiff, mul_res);
          ti    <= ti + 2'd1;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          e  <= e + 6'd1;
          ti <= '0;
        end
      end
      default: ;
    endcase
  end

  assign row_index       = e[5:3];
  assign column_index    = e[2:0];
  assign stiffness_value = stiff;
  assign last_entry      = (e == 6'd63);
  assign zero_area       = flat;

endmodule

FILE: rtl/rstf_checker.sv
// Port-level checks for the stiffness core, bound to the top level.
// Depends on rstf_pkg only through the top level it is bound to.
`timescale 1ns / 1ps

module rstf_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [63:0]        cfg_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [63:0] corner1_x,
  input logic signed [63:0] corner1_y,
  input logic signed [63:0] corner2_x,
  input logic signed [63:0] corner2_y,
  input logic signed [63:0] corner3_x,
  input logic signed [63:0] corner3_y,
  input logic signed [63:0] corner4_x,
  input logic signed [63:0] corner4_y,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         row_index,
  input logic [2:0]         column_index,
  input logic signed [63:0] stiffness_value,
  input logic               last_entry,
  input logic               zero_area
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stiffness_value) &&
      $stable(row_index) && $stable(column_index))
    else $error("result changed while stalled");

  // busy straight after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // no new element while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("ready while results pending");

  // the last entry is the bottom right corner
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_entry |-> row_index == 3'd7 && column_index == 3'd7)
    else $error("last entry at wrong position");

  // a flat element gives zeros
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_area |-> stiffness_value == 64'sd0)
    else $error("flat element with nonzero entry");

endmodule

bind rect_element_stiffness_core rstf_checker u_rstf_checker (.*);

FILE: verif/tb_rect_element_stiffness_core.sv
// Self-checking testbench for rect_element_stiffness_core: drives corner sets and registers,
// predicts all 64 stiffness entries per element and compares them in order.
// Depends on rtl/rstf_pkg.sv and rtl/rect_element_stiffness_core.sv.
`timescale 1ns / 1ps

module tb_rect_element_stiffness_core;
  import rstf_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int LONG_HOLD      = 600;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic signed [63:0] ONE = 64'sh0000_0001_0000_0000;

  typedef logic signed [63:0] corner_set_t [8];

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [63:0] value;
    logic               last;
    logic               flat;
  } stiff_entry_t;

  class stiffness_board;
    logic [6:0]         steps;
    logic signed [63:0] e_xx, e_xy, e_xs, e_yy, e_ys, e_ss;
    longint             gx [4][4];
    longint             gy [4][4];
    longint             rh, rw;
    stiff_entry_t       expected_entries [$];
    int                 mismatches;
    int                 n_xt [4] = '{0, -1, 1, 0};
    int                 n_xu [4] = '{1, 0, 0, -1};
    int                 n_yt [4] = '{0, 0, 1, -1};
    int                 n_yu [4] = '{1, -1, 0, 0};
    int                 sg_x [4] = '{-1, -1, 1, 1};
    int                 sg_y [4] = '{-1, 1, 1, -1};

    function new();
      steps = 7'd2;
      {e_xx, e_xy, e_xs, e_yy, e_ys, e_ss} = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        REG_GRID_STEPS: steps = d[6:0];
        REG_ELASTIC_XX: e_xx = d;
        REG_ELASTIC_XY: e_xy = d;
        REG_ELASTIC_XS: e_xs = d;
        REG_ELASTIC_YY: e_yy = d;
        REG_ELASTIC_YS: e_ys = d;
        REG_ELASTIC_SS: e_ss = d;
        default: ;
      endcase
    endfunction

    function logic [63:0] mag(longint x);
      return x < 0 ? 64'd0 - 64'(x) : 64'(x);
    endfunction

    function longint from_mag(logic [63:0] m, logic neg);
      if (!neg) return m[63] ? SAT_MAX : longint'(m);
      if (m >= 64'h8000_0000_0000_0000) return SAT_MIN;
      return -longint'(m);
    endfunction

    function longint fx_mul(longint a, longint b);
      logic [127:0] p;
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      p = p + 128'h8000_0000;
      if (p[127:96] != 0) return ((a < 0) != (b < 0)) ? SAT_MIN : SAT_MAX;
      return from_mag(p[95:32], (a < 0) != (b < 0));
    endfunction

    function longint fx_add(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? SAT_MIN : SAT_MAX;
      return s[63:0];
    endfunction

    function longint fx_ratio(logic [63:0] num, logic [63:0] den);
      logic [95:0] q;
      q = {num, 32'd0} / {32'd0, den};
      if (q[95:63] != 0) return SAT_MAX;
      return longint'(q[63:0]);
    endfunction

    function void node_coefs(int n);
      longint sxx [4][4];
      longint syy [4][4];
      longint t, u;
      logic [63:0] den, m;
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++) begin
          sxx[a][b] = 0;
          syy[a][b] = 0;
        end
      den = 4 * n * n * n;
      for (int k = 0; k < n; k++) begin
        t = 2 * k + 1;
        u = t - 2 * n;
        for (int a = 0; a < 4; a++)
          for (int b = 0; b < 4; b++) begin
            sxx[a][b] += (n_xt[a] * t + n_xu[a] * u) * (n_xt[b] * t + n_xu[b] * u);
            syy[a][b] += (n_yt[a] * t + n_yu[a] * u) * (n_yt[b] * t + n_yu[b] * u);
          end
      end
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++) begin
          m = ((mag(sxx[a][b]) << 32) + den / 2) / den;
          gx[a][b] = from_mag(m, sxx[a][b] < 0);
          m = ((mag(syy[a][b]) << 32) + den / 2) / den;
          gy[a][b] = from_mag(m, syy[a][b] < 0);
        end
    endfunction

    function longint xq(int a, int b);
      return longint'(sg_x[a] * sg_y[b]) * QUARTER;
    endfunction

    function longint yq(int a, int b);
      return longint'(sg_y[a] * sg_x[b]) * QUARTER;
    endfunction

    function longint entry_uu(int a, int b);
      longint v;
      v = fx_mul(fx_mul(e_xx, rh), gy[a][b]);
      v = fx_add(v, fx_mul(e_xs, yq(a, b) + xq(a, b)));
      return fx_add(v, fx_mul(fx_mul(e_ss, rw), gx[a][b]));
    endfunction

    function longint entry_uv(int a, int b);
      longint v;
      v = fx_mul(e_xy, yq(a, b));
      v = fx_add(v, fx_mul(fx_mul(e_xs, rh), gy[a][b]));
      v = fx_add(v, fx_mul(fx_mul(e_ys, rw), gx[a][b]));
      return fx_add(v, fx_mul(e_ss, xq(a, b)));
    endfunction

    function longint entry_vv(int a, int b);
      longint v;
      v = fx_mul(fx_mul(e_yy, rw), gx[a][b]);
      v = fx_add(v, fx_mul(e_ys, xq(a, b) + yq(a, b)));
      return fx_add(v, fx_mul(fx_mul(e_ss, rh), gy[a][b]));
    endfunction

    // work out the 64 entries of one element
    function void note_element(corner_set_t c);
      longint lo_x, hi_x, lo_y, hi_y;
      logic [63:0] w, h;
      logic flat;
      int n;
      stiff_entry_t ent;
      lo_x = c[0]; hi_x = c[0]; lo_y = c[1]; hi_y = c[1];
      for (int i = 1; i < 4; i++) begin
        if (c[2*i] < lo_x) lo_x = c[2*i];
        if (c[2*i] > hi_x) hi_x = c[2*i];
        if (c[2*i+1] < lo_y) lo_y = c[2*i+1];
        if (c[2*i+1] > hi_y) hi_y = c[2*i+1];
      end
      w = 64'(hi_x) - 64'(lo_x);
      h = 64'(hi_y) - 64'(lo_y);
      flat = (w == 0) || (h == 0);
      n = steps == 0 ? 1 : (steps > MAX_STEPS ? MAX_STEPS : int'(steps));
      if (!flat) begin
        node_coefs(n);
        rh = fx_ratio(h, w);
        rw = fx_ratio(w, h);
      end
      for (int r = 0; r < 8; r++)
        for (int k = 0; k < 8; k++) begin
          ent.row = 3'(r);
          ent.col = 3'(k);
          ent.last = (r == 7) && (k == 7);
          ent.flat = flat;
          if (flat) ent.value = 0;
          else if (r < 4 && k < 4) ent.value = entry_uu(r, k);
          else if (r < 4) ent.value = entry_uv(r, k - 4);
          else if (k < 4) ent.value = entry_uv(k, r - 4);
          else ent.value = entry_vv(r - 4, k - 4);
          expected_entries.push_back(ent);
        end
    endfunction

    function void check_entry(stiff_entry_t got);
      stiff_entry_t exp_e;
      if (expected_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected entry r%0d c%0d value %h", got.row, got.col, got.value);
        return;
      end
      exp_e = expected_entries.pop_front();
      if (got.row !== exp_e.row || got.col !== exp_e.col || got.value !== exp_e.value ||
          got.last !== exp_e.last || got.flat !== exp_e.flat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp r%0d c%0d %h last %b flat %b, got r%0d c%0d %h last %b flat %b",
                   exp_e.row, exp_e.col, exp_e.value, exp_e.last, exp_e.flat,
                   got.row, got.col, got.value, got.last, got.flat);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [63:0] corner [8] = '{default: '0};
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         row_index, column_index;
  logic signed [63:0] stiffness_value;
  logic               last_entry, zero_area;

  stiffness_board board = new();
  logic idling = 1'b1;
  logic hold_req = 1'b0;
  int   quiet_cycles = 0;

  rect_element_stiffness_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .corner1_x(corner[0]), .corner1_y(corner[1]),
    .corner2_x(corner[2]), .corner2_y(corner[3]),
    .corner3_x(corner[4]), .corner3_y(corner[5]),
    .corner4_x(corner[6]), .corner4_y(corner[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_index(row_index), .column_index(column_index),
    .stiffness_value(stiffness_value), .last_entry(last_entry), .zero_area(zero_area)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random stalls while idling is set, plus one long hold on request
  initial begin
    int k;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        k = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (k - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    stiff_entry_t got;
    if (!rst && out_valid && out_ready) begin
      got.row = row_index;
      got.col = column_index;
      got.value = stiffness_value;
      got.last = last_entry;
      got.flat = zero_area;
      board.check_entry(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (in_valid || board.expected_entries.size() != 0) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    board.write_reg(idx, d);
  endtask

  task automatic load_config(logic [6:0] steps, logic signed [63:0] xx, xy, xs, yy, ys, ss);
    write_reg(REG_GRID_STEPS, {57'd0, steps});
    write_reg(REG_ELASTIC_XX, xx);
    write_reg(REG_ELASTIC_XY, xy);
    write_reg(REG_ELASTIC_XS, xs);
    write_reg(REG_ELASTIC_YY, yy);
    write_reg(REG_ELASTIC_YS, ys);
    write_reg(REG_ELASTIC_SS, ss);
    // unused index must leave everything alone
    write_reg(REG_UNUSED, rand64());
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (board.expected_entries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_element(corner_set_t c);
    int k;
    if (idling && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (k) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 8; i++) corner[i] <= c[i];
    do @(posedge clk); while (!in_ready);
    board.note_element(c);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_rect(longint x0, y0, x1, y1);
    corner_set_t c;
    c = '{x0, y0, x1, y0, x1, y1, x0, y1};
    send_element(c);
  endtask

  // mostly true rectangles in shuffled corner order, some noise and skewed quads
  task automatic send_random();
    corner_set_t c;
    longint px [4];
    longint py [4];
    longint x0, y0, x1, y1;
    int start, dir, mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      for (int i = 0; i < 8; i++) c[i] = rand64();
    end else begin
      x0 = $signed(rand64()) >>> $urandom_range(16, 40);
      y0 = $signed(rand64()) >>> $urandom_range(16, 40);
      x1 = x0 + longint'((rand64() >> $urandom_range(20, 40)) | 64'd1);
      y1 = y0 + longint'((rand64() >> $urandom_range(20, 40)) | 64'd1);
      px = '{x0, x1, x1, x0};
      py = '{y0, y0, y1, y1};
      start = $urandom_range(0, 3);
      dir = $urandom_range(0, 1) ? 1 : 3;
      for (int i = 0; i < 4; i++) begin
        c[2*i]   = px[(start + dir * i) % 4];
        c[2*i+1] = py[(start + dir * i) % 4];
      end
      if (mode == 1) c[$urandom_range(0, 7)] = rand64() >>> $urandom_range(16, 40);
    end
    send_element(c);
  endtask

  function automatic logic signed [63:0] rand_elastic();
    return $signed(rand64()) >>> $urandom_range(12, 30);
  endfunction

  task automatic random_phase(int items);
    load_config($urandom_range(0, 5) == 0 ? 7'($urandom_range(7, 12)) : 7'($urandom_range(1, 5)),
                rand_elastic(), rand_elastic(), rand_elastic(),
                rand_elastic(), rand_elastic(), rand_elastic());
    for (int i = 0; i < items; i++) send_random();
    end_burst();
    drain();
  endtask

  initial begin
    corner_set_t c;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at their reset values: all entries zero
    send_rect(0, 0, ONE, ONE);
    send_rect(5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE);
    end_burst();
    drain();

    load_config(7'd1, 3 * ONE, ONE, ONE / 4, 2 * ONE, -ONE / 2, ONE / 3);
    send_rect(0, 0, ONE, ONE);
    c = '{0, 0, 2 * ONE, 3 * ONE, 0, 3 * ONE, 2 * ONE, 0};
    send_element(c);
    // maximum only on the second corner
    c = '{0, 0, 4 * ONE, 2 * ONE, ONE, ONE, 0, ONE};
    send_element(c);
    send_rect(-7 * ONE, -3 * ONE, -2 * ONE, -ONE);
    send_rect(ONE, 2 * ONE, ONE, 9 * ONE);
    send_rect(ONE, 2 * ONE, 6 * ONE, 2 * ONE);
    send_rect(0, 0, 64'sd1, 64'sh0000_0100_0000_0000);
    send_rect(0, 0, 64'sh0000_0100_0000_0000, 64'sd1);
    send_rect(SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX);
    c = '{64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA, 64'shAAAA_AAAA_AAAA_AAAA,
          64'sh5555_5555_5555_5555, -64'sd1, 64'sd0, 64'sd0, -64'sd1};
    send_element(c);
    end_burst();
    drain();

    // steps zero acts as one; extreme elasticity saturates
    load_config(7'd0, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);
    send_rect(0, 0, 1000 * ONE, ONE);
    send_rect(SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX);
    send_rect(0, 0, ONE, ONE);
    end_burst();
    drain();

    // steps above the maximum clamp, then steps exactly at the maximum
    load_config(7'd127, ONE, -ONE, 2 * ONE, -3 * ONE, ONE / 2, -ONE / 5);
    send_rect(0, 0, 3 * ONE, 2 * ONE);
    end_burst();
    drain();
    load_config(7'd64, 2 * ONE, ONE / 2, 0, 2 * ONE, 0, ONE / 2);
    send_rect(-ONE, -ONE, ONE, 4 * ONE);
    end_burst();
    drain();

    for (int p = 0; p < 3; p++) random_phase(15);

    // long receiver hold while the sender keeps offering, then wait for all results
    load_config(7'd2, rand_elastic(), rand_elastic(), rand_elastic(),
                rand_elastic(), rand_elastic(), rand_elastic());
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_random();
    end_burst();
    drain();
    for (int i = 0; i < 6; i++) send_random();
    end_burst();
    drain();

    idling = 1'b0;
    random_phase(20);

    repeat (100) @(posedge clk);
    if (board.mismatches == 0 && board.expected_entries.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
